@@ design/rmt_pkg.sv @@
// Shared constants, codes and types of the running median tracker.
package rmt_pkg;

  localparam int CAPACITY   = 1024;
  localparam int HEAP_DEPTH = CAPACITY / 2 + 1;
  localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
  localparam int SAMPLE_W   = 32;
  localparam int MED_W      = 33;
  localparam int COUNT_W    = 11;

  // Row commands
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [1:0] op;
    logic       is_max;
    sample_t    value;
  } cell_cmd_t;

endpackage

@@ design/rmt_cell.sv @@
// One cell of a sorted row: holds one value, inserts or shifts toward the head.
module rmt_cell (
  input  logic               clk,
  input  rmt_pkg::cell_cmd_t cmd,
  input  logic               live,
  input  logic               left_keep,
  input  rmt_pkg::sample_t   left_val,
  input  rmt_pkg::sample_t   right_val,
  output rmt_pkg::sample_t   val,
  output logic               keep
);

  rmt_pkg::sample_t val_r;
  rmt_pkg::sample_t val_nxt;
  logic             ahead;

  // Own value stays ahead of the new one (ties stay too)
  always_comb begin
    if (cmd.is_max) begin
      ahead = ($signed(val_r) >= $signed(cmd.value));
    end else begin
      ahead = ($signed(val_r) <= $signed(cmd.value));
    end
  end

  assign keep = live && ahead;

  always_comb begin
    unique case (cmd.op)
      rmt_pkg::OP_PUSH: begin
        if (keep) begin
          val_nxt = val_r;
        end else if (left_keep) begin
          val_nxt = cmd.value;
        end else begin
          val_nxt = left_val;
        end
      end
      rmt_pkg::OP_POP: begin
        val_nxt = right_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

@@ design/rmt_chain.sv @@
// Row of cells kept sorted with its best value at the head cell.
module rmt_chain (
  input  logic                       clk,
  input  rmt_pkg::cell_cmd_t         cmd,
  input  logic [rmt_pkg::SIZE_W-1:0] size,
  output rmt_pkg::sample_t           head
);

  rmt_pkg::sample_t                 vals [rmt_pkg::HEAP_DEPTH];
  logic [rmt_pkg::HEAP_DEPTH-1:0]   keeps;

  for (genvar i = 0; i < rmt_pkg::HEAP_DEPTH; i++) begin : g_cell
    logic             live;
    logic             lk;
    rmt_pkg::sample_t lv;
    rmt_pkg::sample_t rv;

    assign live = (size > rmt_pkg::SIZE_W'(i));

    if (i == 0) begin : g_first
      assign lk = 1'b1;
      assign lv = cmd.value;
    end else begin : g_inner
      assign lk = keeps[i-1];
      assign lv = vals[i-1];
    end

    if (i == rmt_pkg::HEAP_DEPTH - 1) begin : g_last
      assign rv = vals[i];
    end else begin : g_body
      assign rv = vals[i+1];
    end

    rmt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .live      (live),
      .left_keep (lk),
      .left_val  (lv),
      .right_val (rv),
      .val       (vals[i]),
      .keep      (keeps[i])
    );
  end

  assign head = vals[0];

endmodule

@@ design/running_median_tracker.sv @@
// Running median tracker: two sorted cell rows stand for the lower and upper halves.
// A sample that fits is pushed, moved and balanced, then the result is loaded; a rejected sample
// goes straight to the result load, which sets out_tvalid. A new sample is taken only once the last
// result is loaded, and the load waits while an unread result is held and out_tready is low;
// a finished result waits in the output register while the next sample is taken.
// Reset: rst_n (synchronous, active low) clears sizes, sequencer and out_tvalid, not the cells.
module running_median_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [32:0] median_doubled, [43:33] sample_count, rest zero
  output logic        out_tuser   // [0] rejected
);

  localparam int         SW       = rmt_pkg::SIZE_W;
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MOVE  = 2'd1;
  localparam logic [1:0] ST_BAL   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [SW-1:0]                lower_size_r, lower_size_nxt;
  logic [SW-1:0]                upper_size_r, upper_size_nxt;
  logic                         rej_r, rej_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rmt_pkg::MED_W-1:0]    out_med_r, out_med_nxt;
  logic [rmt_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                         out_rej_r, out_rej_nxt;

  rmt_pkg::cell_cmd_t lower_cmd, upper_cmd;
  rmt_pkg::sample_t   lower_head, upper_head;
  logic [SW:0]        count;
  logic               full;
  logic               in_acc;
  logic               out_load;

  // Lower half: descending row, head holds its largest value.
  rmt_chain u_lower (
    .clk  (clk),
    .cmd  (lower_cmd),
    .size (lower_size_r),
    .head (lower_head)
  );

  // Upper half: ascending row, head holds its smallest value.
  rmt_chain u_upper (
    .clk  (clk),
    .cmd  (upper_cmd),
    .size (upper_size_r),
    .head (upper_head)
  );

  assign count     = {1'b0, lower_size_r} + {1'b0, upper_size_r};
  assign full      = (32'(count) >= 32'(rmt_pkg::CAPACITY));
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt        = state_r;
    lower_size_nxt   = lower_size_r;
    upper_size_nxt   = upper_size_r;
    rej_nxt          = rej_r;
    lower_cmd        = '0;
    upper_cmd        = '0;
    lower_cmd.op     = rmt_pkg::OP_HOLD;
    lower_cmd.is_max = 1'b1;
    upper_cmd.op     = rmt_pkg::OP_HOLD;
    upper_cmd.is_max = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rej_nxt = full;
          if (full) begin
            // Drop the sample; report the unchanged set.
            state_nxt = ST_DONE;
          end else begin
            // Push the sample into the lower half.
            lower_cmd.op    = rmt_pkg::OP_PUSH;
            lower_cmd.value = in_tdata;
            lower_size_nxt  = lower_size_r + SW'(1);
            state_nxt       = ST_MOVE;
          end
        end
      end
      ST_MOVE: begin
        // Move the lower top into the upper half.
        lower_cmd.op    = rmt_pkg::OP_POP;
        upper_cmd.op    = rmt_pkg::OP_PUSH;
        upper_cmd.value = lower_head;
        lower_size_nxt  = lower_size_r - SW'(1);
        upper_size_nxt  = upper_size_r + SW'(1);
        state_nxt       = ST_BAL;
      end
      ST_BAL: begin
        // Hand the upper top back if the upper half grew larger.
        if (lower_size_r < upper_size_r) begin
          upper_cmd.op    = rmt_pkg::OP_POP;
          lower_cmd.op    = rmt_pkg::OP_PUSH;
          lower_cmd.value = upper_head;
          lower_size_nxt  = lower_size_r + SW'(1);
          upper_size_nxt  = upper_size_r - SW'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result: doubled middle for an odd count, sum of both middles for an even one, zero when empty.
  always_comb begin
    out_med_nxt   = out_med_r;
    out_count_nxt = out_count_r;
    out_rej_nxt   = out_rej_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_rej_nxt   = rej_r;
      out_count_nxt = rmt_pkg::COUNT_W'(count);
      if (lower_size_r > upper_size_r) begin
        out_med_nxt = {lower_head, 1'b0};
      end else if (lower_size_r != '0) begin
        out_med_nxt = {lower_head[31], lower_head} + {upper_head[31], upper_head};
      end else begin
        out_med_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lower_size_r <= '0;
      upper_size_r <= '0;
      rej_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lower_size_r <= lower_size_nxt;
      upper_size_r <= upper_size_nxt;
      rej_r        <= rej_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload holds without reset.
  always_ff @(posedge clk) begin
    out_med_r   <= out_med_nxt;
    out_count_r <= out_count_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_count_r, out_med_r};
  assign out_tuser  = out_rej_r;

  // Between samples the lower half equals the upper half or holds one more.
  a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |->
      ((lower_size_r == upper_size_r) || (lower_size_r == upper_size_r + SW'(1))))
    else $error("halves out of balance");

  // The set never holds more than the capacity.
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (32'(count) <= 32'(rmt_pkg::CAPACITY)))
    else $error("sample count above capacity");

  // A rejected result reports a full store.
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |->
      (out_count_r == rmt_pkg::COUNT_W'(rmt_pkg::CAPACITY)))
    else $error("rejected result without full store");

  // An accepted sample that fits lands in the lower half first.
  a_push_lower: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !full) |=> (lower_size_r == $past(lower_size_r) + SW'(1)))
    else $error("accepted sample not pushed");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the running median tracker: stream driver, result monitor, predictor.
module tb;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 4;
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off, fills the block
  localparam int STALL_LIMIT     = 5000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES    = 20;    // settle time after the last result
  localparam int MAX_REPORTS     = 10;

  localparam rmt_pkg::sample_t S_MIN = rmt_pkg::sample_t'(32'h8000_0000);
  localparam rmt_pkg::sample_t S_MAX = rmt_pkg::sample_t'(32'h7fff_ffff);

  // Idle profile applied to both channels while items of a phase are in flight
  typedef enum logic [1:0] {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} idle_phase_t;

  typedef struct packed {
    rmt_pkg::sample_t sample;
    idle_phase_t      phase;
    logic             hold_sink;    // start the long receiver hold-off once this one is taken
    logic             drain_first;  // offer only after every pending median has come back
  } sample_item_t;

  typedef struct packed {
    logic signed [rmt_pkg::MED_W-1:0] median_doubled;
    logic [rmt_pkg::COUNT_W-1:0]      sample_count;
    logic                             rejected;
  } median_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // [31:0] sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // [32:0] median_doubled, [43:33] sample_count
  logic        out_tuser;        // [0] rejected

  sample_item_t     pending_items[$];
  median_result_t   expected_medians[$];
  rmt_pkg::sample_t held_sorted[$];    // every sample the block holds, ascending
  sample_item_t     offered_item;
  logic             in_taken      = 1'b0;
  logic             hold_armed    = 1'b0;
  int unsigned      hold_left     = 0;
  int unsigned      src_idle_pct  = 0;
  int unsigned      snk_stall_pct = 0;
  int unsigned      fail_count    = 0;
  int unsigned      quiet_cycles  = 0;

  running_median_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // Add one sample to the held set (unless the store is full) and work out the
  // doubled median of the set. A sorted list gives the same middle values as the
  // two sorted rows: the lower middle sits at (n-1)/2, the upper at n/2, and for an odd
  // count both point at the same entry, which yields twice the middle value.
  function automatic median_result_t predict_median(rmt_pkg::sample_t s);
    median_result_t r;
    int unsigned    pos;
    int unsigned    n;
    longint         lo_mid;
    longint         hi_mid;
    r.rejected = 1'b0;
    if (held_sorted.size() >= rmt_pkg::CAPACITY) begin
      r.rejected = 1'b1;  // store full: drop, report the unchanged set
    end else begin
      pos = 0;
      while (pos < held_sorted.size() && held_sorted[pos] <= s) pos++;
      held_sorted.insert(pos, s);
    end
    n      = held_sorted.size();
    lo_mid = 0;
    hi_mid = 0;
    if (n > 0) begin
      lo_mid = held_sorted[(n - 1) / 2];
      hi_mid = held_sorted[n / 2];
    end
    r.median_doubled = rmt_pkg::MED_W'(lo_mid + hi_mid);
    r.sample_count   = rmt_pkg::COUNT_W'(n);
    return r;
  endfunction

  // Queue random samples: mostly full-range words, with extremes and a narrow band
  // around zero mixed in so that duplicates and ties in the middle show up often.
  task automatic queue_random(int unsigned count, idle_phase_t phase,
                              logic drain_first, logic hold_sink);
    sample_item_t item;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: begin
          case ($urandom_range(4))
            0:       item.sample = S_MIN;
            1:       item.sample = S_MAX;
            2:       item.sample = '0;
            3:       item.sample = '1;
            default: item.sample = rmt_pkg::sample_t'(1);
          endcase
        end
        1, 2:    item.sample = rmt_pkg::sample_t'(int'($urandom_range(20)) - 10);
        default: item.sample = rmt_pkg::sample_t'($urandom);
      endcase
      item.phase       = phase;
      item.drain_first = drain_first && (i == 0);
      item.hold_sink   = hold_sink && (i == 5);
      pending_items.push_back(item);
    end
  endtask

  // Monitor: sample both handshakes at the rising edge, predict on every input
  // transaction and check every output transaction against the oldest prediction.
  always @(posedge clk) begin : monitor
    median_result_t                   want;
    logic signed [rmt_pkg::MED_W-1:0] got_med;
    logic [rmt_pkg::COUNT_W-1:0]      got_count;
    logic                             out_fire;
    in_taken = in_tvalid && in_tready;
    out_fire = out_tvalid && out_tready;
    if (in_taken) begin
      expected_medians.push_back(predict_median(offered_item.sample));
      // Switch both idle profiles to the phase of the item just taken
      case (offered_item.phase)
        PH_FREE: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        PH_SRC_IDLE: begin
          src_idle_pct  = 61;
          snk_stall_pct = 0;
        end
        PH_SNK_STALL: begin
          src_idle_pct  = 0;
          snk_stall_pct = 61;
        end
        default: begin
          src_idle_pct  = 23;
          snk_stall_pct = 23;
        end
      endcase
      if (offered_item.hold_sink) hold_armed = 1'b1;
    end
    if (out_fire) begin
      got_med   = out_tdata[rmt_pkg::MED_W-1:0];
      got_count = out_tdata[rmt_pkg::MED_W+rmt_pkg::COUNT_W-1:rmt_pkg::MED_W];
      if (expected_medians.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result at %0t: median2 %0d count %0d rejected %0b",
                   $time, got_med, got_count, out_tuser);
      end else begin
        want = expected_medians.pop_front();
        if (got_med !== want.median_doubled || got_count !== want.sample_count ||
            out_tuser !== want.rejected) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch at %0t: median2 exp %0d got %0d, count exp %0d got %0d, %s%0b %s%0b",
                     $time, want.median_doubled, got_med, want.sample_count, got_count,
                     "rejected exp ", want.rejected, "got ", out_tuser);
        end
      end
    end
    quiet_cycles = (in_taken || out_fire) ? 0 : quiet_cycles + 1;
  end

  // Driver: advance to the next sample once the current one is taken, or insert
  // an idle cycle as the phase asks. Hold a drain-first item back until the
  // block has returned every pending median.
  always @(negedge clk) begin : driver
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_items.size() > 0 &&
          !(pending_items[0].drain_first && expected_medians.size() > 0) &&
          $urandom_range(99) >= src_idle_pct) begin
        offered_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= offered_item.sample;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random per phase; on request drop tready for a long
  // stretch so the block backs up and stalls its input.
  always @(negedge clk) begin : receiver
    if (hold_armed) begin
      hold_left  = HOLD_OFF_CYCLES;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rmt_pkg::sample_t directed[$];
    sample_item_t     item;
    // Extremes first: two minima give the lowest doubled median, and after six
    // maxima the two middle values are both the maximum. Then the values around
    // zero and alternating bit patterns.
    directed = '{S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                 rmt_pkg::sample_t'(0), rmt_pkg::sample_t'(-1), rmt_pkg::sample_t'(1),
                 rmt_pkg::sample_t'(0), rmt_pkg::sample_t'(-1),
                 rmt_pkg::sample_t'(32'h5555_5555), rmt_pkg::sample_t'(32'haaaa_aaaa),
                 rmt_pkg::sample_t'(32'h0000_ffff), rmt_pkg::sample_t'(32'hffff_0000),
                 rmt_pkg::sample_t'(1)};
    foreach (directed[i]) begin
      item.sample      = directed[i];
      item.phase       = PH_FREE;
      item.hold_sink   = 1'b0;
      item.drain_first = 1'b0;
      pending_items.push_back(item);
    end
    // Pause the sender after the directed part, then back the block up
    queue_random(150, PH_FREE, 1'b1, 1'b1);
    queue_random(250, PH_SRC_IDLE, 1'b1, 1'b0);
    queue_random(250, PH_SNK_STALL, 1'b0, 1'b0);
    queue_random(250, PH_BOTH, 1'b0, 1'b0);
    // This stretch crosses the store's capacity, so the tail gets dropped
    queue_random(150, PH_FREE, 1'b1, 1'b1);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last transaction and every pending median, then let the block settle
    while (pending_items.size() > 0 || in_tvalid || expected_medians.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
